[hdl/ptg_pkg.sv]
// Package for the planar texture coordinate generator: word types, sequencer
// states and basis constants. No dependencies.
`default_nettype none
package ptg_pkg;

    localparam int BASIS_FRAC = 30;

    typedef struct packed {
        logic               first_vertex;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               degenerate;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCALE_MAX,
        ST_SCALE_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_DIV_STORE,
        ST_NRM_SCALE,
        ST_CROSS,
        ST_PROJ,
        ST_PROJ_SUM,
        ST_OUT
    } state_t;

    // Which vector the normalize sequence is working on
    typedef enum logic [1:0] {
        VEC_EDGE,
        VEC_NORMAL,
        VEC_CROSS
    } vsel_t;

endpackage
`default_nettype wire

[hdl/ptg_core.sv]
// Sequenced datapath for the texture coordinate generator: one shared
// multiplier, one shared restoring sqrt/divide step. Uses ptg_pkg.
`default_nettype none
module ptg_core #(
    parameter int UV_SCALE_SHIFT = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire ptg_pkg::in_word_t   in_word,
    output logic                     done,
    output ptg_pkg::out_word_t       out_word
);

    localparam int K = ptg_pkg::BASIS_FRAC + UV_SCALE_SHIFT;

    ptg_pkg::state_t state_reg, state_next;
    ptg_pkg::vsel_t  vsel_reg;

    logic signed [31:0] org_reg [3];
    logic signed [31:0] uax_reg [3];
    logic signed [31:0] vax_reg [3];
    logic [1:0]         pos_reg;
    logic               degen_reg;

    // working vector (holds edge, normal or cross product)
    logic signed [66:0] w_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [31:0] nrm_reg [3];
    logic [66:0]        max_reg;
    logic [1:0]         idx_reg;
    logic [6:0]         cnt_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        r_reg;
    logic [61:0]        num_reg;
    logic [31:0]        quo_reg;
    logic signed [31:0] res_reg [3];
    logic signed [95:0] acc_reg;
    logic signed [31:0] tu_reg;
    logic               pass_reg;
    logic               flag_reg;

    // ---- shared multiplier: 33x32 signed ----
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    assign mul_p = mul_a * mul_b;

    function automatic logic [66:0] mag67(input logic signed [66:0] x);
        return x[66] ? 67'(-x) : 67'(x);
    endfunction

    // magnitudes of the current and the next component
    logic [66:0] cur_mag;
    logic [1:0]  nxt_idx;
    logic [66:0] nxt_mag;
    assign cur_mag = mag67(w_reg[idx_reg]);
    assign nxt_idx = idx_reg + 2'd1;
    assign nxt_mag = mag67(w_reg[nxt_idx]);

    // projection term with rounding shift is done once on the 96-bit sum
    logic signed [95:0] proj_rnd;
    logic signed [95:0] proj_sh;
    logic signed [31:0] proj_sat;
    assign proj_rnd = acc_reg + (96'sd1 <<< (K - 1));
    assign proj_sh  = proj_rnd >>> K;
    always_comb
    begin
        if (proj_sh > 96'sh7FFFFFFF)
            proj_sat = 32'sh7FFFFFFF;
        else if (proj_sh < -96'sh80000000)
            proj_sat = 32'sh80000000;
        else
            proj_sat = proj_sh[31:0];
    end

    // sqrt step
    logic [63:0] sq_try;
    assign sq_try = root_reg + bit_reg;

    // divide step: shift numerator into remainder
    logic [63:0] div_rem;
    assign div_rem = {rem_reg[62:0], num_reg[61]};

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ptg_pkg::ST_SQ:
            begin
                mul_a = 33'(w_reg[idx_reg]);
                mul_b = w_reg[idx_reg][31:0];
            end
            ptg_pkg::ST_CROSS:
            begin
                // cnt bit0: first or second product of the component
                unique case ({idx_reg, cnt_reg[0]})
                    3'b000:  begin mul_a = 33'(nrm_reg[1]); mul_b = uax_reg[2]; end
                    3'b001:  begin mul_a = 33'(nrm_reg[2]); mul_b = uax_reg[1]; end
                    3'b010:  begin mul_a = 33'(nrm_reg[2]); mul_b = uax_reg[0]; end
                    3'b011:  begin mul_a = 33'(nrm_reg[0]); mul_b = uax_reg[2]; end
                    3'b100:  begin mul_a = 33'(nrm_reg[0]); mul_b = uax_reg[1]; end
                    3'b101:  begin mul_a = 33'(nrm_reg[1]); mul_b = uax_reg[0]; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ptg_pkg::ST_PROJ:
            begin
                mul_a = d_reg[idx_reg];
                mul_b = pass_reg ? vax_reg[idx_reg] : uax_reg[idx_reg];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptg_pkg::ST_IDLE:      if (start) state_next = ptg_pkg::ST_DIFF;
            default:               state_next = state_reg;
        endcase
    end

    // main sequencer: datapath and state updated together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptg_pkg::ST_IDLE;
            vsel_reg  <= ptg_pkg::VEC_EDGE;
            pos_reg   <= '0;
            degen_reg <= 1'b0;
            done      <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                uax_reg[i] <= '0;
                vax_reg[i] <= '0;
            end
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                ptg_pkg::ST_IDLE:
                begin
                    state_reg <= state_next;
                end
                ptg_pkg::ST_DIFF:
                begin
                    d_reg[0] <= 33'(in_word.vert_x) - 33'(org_reg[0]);
                    d_reg[1] <= 33'(in_word.vert_y) - 33'(org_reg[1]);
                    d_reg[2] <= 33'(in_word.vert_z) - 33'(org_reg[2]);
                    nrm_reg[0] <= in_word.normal_x;
                    nrm_reg[1] <= in_word.normal_y;
                    nrm_reg[2] <= in_word.normal_z;
                    w_reg[0] <= 67'(33'(in_word.vert_x) - 33'(org_reg[0]));
                    w_reg[1] <= 67'(33'(in_word.vert_y) - 33'(org_reg[1]));
                    w_reg[2] <= 67'(33'(in_word.vert_z) - 33'(org_reg[2]));
                    idx_reg  <= '0;
                    max_reg  <= '0;
                    flag_reg <= 1'b0;
                    if (in_word.first_vertex || pos_reg == 2'd0)
                    begin
                        org_reg[0] <= in_word.vert_x;
                        org_reg[1] <= in_word.vert_y;
                        org_reg[2] <= in_word.vert_z;
                        pos_reg    <= 2'd1;
                        degen_reg  <= 1'b0;
                        out_word   <= '0;
                        state_reg  <= ptg_pkg::ST_OUT;
                    end
                    else if (pos_reg == 2'd1)
                    begin
                        vsel_reg  <= ptg_pkg::VEC_EDGE;
                        state_reg <= ptg_pkg::ST_SCALE_MAX;
                    end
                    else if (degen_reg)
                    begin
                        out_word  <= '{tex_u: '0, tex_v: '0, degenerate: 1'b1};
                        state_reg <= ptg_pkg::ST_OUT;
                    end
                    else
                    begin
                        pass_reg  <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= ptg_pkg::ST_PROJ;
                    end
                end
                // largest magnitude over the three components
                ptg_pkg::ST_SCALE_MAX:
                begin
                    if (cur_mag > max_reg)
                        max_reg <= cur_mag;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        if (cur_mag == 0 && max_reg == 0)
                            flag_reg <= 1'b1;
                        state_reg <= ptg_pkg::ST_SCALE_SHIFT;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                // one bit of shift per cycle until max sits in [2^29, 2^30)
                ptg_pkg::ST_SCALE_SHIFT:
                begin
                    if (flag_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            uax_reg[i] <= '0;
                            vax_reg[i] <= '0;
                        end
                        degen_reg <= 1'b1;
                        pos_reg   <= 2'd2;
                        out_word  <= '{tex_u: '0, tex_v: '0, degenerate: 1'b1};
                        state_reg <= ptg_pkg::ST_OUT;
                    end
                    else if (max_reg >= (67'd1 << 30))
                    begin
                        max_reg <= max_reg >> 1;
                        for (int i = 0; i < 3; i++)
                            w_reg[i] <= w_reg[i] >>> 1;
                    end
                    else if (max_reg < (67'd1 << 29))
                    begin
                        max_reg <= max_reg << 1;
                        for (int i = 0; i < 3; i++)
                            w_reg[i] <= w_reg[i] <<< 1;
                    end
                    else if (vsel_reg == ptg_pkg::VEC_NORMAL)
                    begin
                        for (int i = 0; i < 3; i++)
                            nrm_reg[i] <= w_reg[i][31:0];
                        idx_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ptg_pkg::ST_CROSS;
                    end
                    else
                    begin
                        sum_reg   <= '0;
                        state_reg <= ptg_pkg::ST_SQ;
                    end
                end
                // sum of squares, one component per cycle
                ptg_pkg::ST_SQ:
                begin
                    sum_reg <= sum_reg + 64'(mul_p);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        rem_reg   <= sum_reg + 64'(mul_p);
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= ptg_pkg::ST_SQRT;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                // restoring square root, one result bit per cycle
                ptg_pkg::ST_SQRT:
                begin
                    if (bit_reg == 0)
                    begin
                        r_reg     <= root_reg[31:0];
                        idx_reg   <= '0;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        num_reg   <= {1'b0, cur_mag[30:0], 30'd0} + 62'(root_reg[31:1]);
                        state_reg <= ptg_pkg::ST_DIV;
                    end
                    else
                    begin
                        if (rem_reg >= sq_try)
                        begin
                            rem_reg  <= rem_reg - sq_try;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                            root_reg <= root_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                // restoring divide, one quotient bit per cycle
                ptg_pkg::ST_DIV:
                begin
                    num_reg <= num_reg << 1;
                    if (div_rem >= 64'(r_reg))
                    begin
                        rem_reg <= div_rem - 64'(r_reg);
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_rem;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    if (cnt_reg == 7'd61)
                        state_reg <= ptg_pkg::ST_DIV_STORE;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ptg_pkg::ST_DIV_STORE:
                begin
                    res_reg[idx_reg] <= w_reg[idx_reg][66] ? -quo_reg : quo_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg <= '0;
                        if (vsel_reg == ptg_pkg::VEC_EDGE)
                        begin
                            uax_reg[0] <= res_reg[0];
                            uax_reg[1] <= res_reg[1];
                            uax_reg[2] <= w_reg[2][66] ? -quo_reg : quo_reg;
                            vsel_reg   <= ptg_pkg::VEC_NORMAL;
                            w_reg[0]   <= 67'(nrm_reg[0]);
                            w_reg[1]   <= 67'(nrm_reg[1]);
                            w_reg[2]   <= 67'(nrm_reg[2]);
                            max_reg    <= '0;
                            state_reg  <= ptg_pkg::ST_SCALE_MAX;
                        end
                        else
                        begin
                            vax_reg[0] <= res_reg[0];
                            vax_reg[1] <= res_reg[1];
                            vax_reg[2] <= w_reg[2][66] ? -quo_reg : quo_reg;
                            degen_reg  <= 1'b0;
                            pos_reg    <= 2'd2;
                            pass_reg   <= 1'b0;
                            acc_reg    <= '0;
                            state_reg  <= ptg_pkg::ST_PROJ;
                        end
                    end
                    else
                    begin
                        idx_reg   <= nxt_idx;
                        num_reg   <= {1'b0, nxt_mag[30:0], 30'd0} + 62'(r_reg[31:1]);
                        state_reg <= ptg_pkg::ST_DIV;
                    end
                end
                // cross product: two products per component
                ptg_pkg::ST_CROSS:
                begin
                    if (!cnt_reg[0])
                        w_reg[idx_reg] <= 67'(mul_p);
                    else
                        w_reg[idx_reg] <= w_reg[idx_reg] - 67'(mul_p);
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg[0])
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            max_reg   <= '0;
                            vsel_reg  <= ptg_pkg::VEC_CROSS;
                            state_reg <= ptg_pkg::ST_SCALE_MAX;
                        end
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                end
                // exact dot product, one term per cycle
                ptg_pkg::ST_PROJ:
                begin
                    acc_reg <= acc_reg + 96'(mul_p);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ptg_pkg::ST_PROJ_SUM;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                ptg_pkg::ST_PROJ_SUM:
                begin
                    acc_reg <= '0;
                    if (!pass_reg)
                    begin
                        tu_reg    <= proj_sat;
                        pass_reg  <= 1'b1;
                        state_reg <= ptg_pkg::ST_PROJ;
                    end
                    else
                    begin
                        out_word  <= '{tex_u: tu_reg, tex_v: proj_sat, degenerate: 1'b0};
                        state_reg <= ptg_pkg::ST_OUT;
                    end
                end
                ptg_pkg::ST_OUT:
                begin
                    done      <= 1'b1;
                    state_reg <= ptg_pkg::ST_IDLE;
                end
                default: state_reg <= ptg_pkg::ST_IDLE;
            endcase
        end
    end

    // the face position never goes back to empty once a face is open
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(pos_reg) != 2'd0 |-> pos_reg != 2'd0)
        else $error("face position returned to empty");
    // a degenerate face has cleared axes
    assert property (@(posedge clk) disable iff (!rst_n)
        (degen_reg && state_reg == ptg_pkg::ST_IDLE) |->
            (uax_reg[0] == 0 && vax_reg[0] == 0))
        else $error("degenerate face kept an axis");
    // done is a one cycle pulse leaving the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ptg_pkg::ST_IDLE)
        else $error("done outside idle");

endmodule
`default_nettype wire

[hdl/planar_texcoord_generator.sv]
// Top level of the planar texture coordinate generator: handshake and
// output register around ptg_core. Uses ptg_pkg.
//
// Input channel in_valid/in_stall/in_data carries one vertex word per face
// vertex; first_vertex starts a new face. Output channel out_valid/out_stall/
// out_data gives one (tex_u, tex_v, degenerate) word per vertex, in order.
// One vertex is in work at a time; in_stall is high while it is.
// Work per vertex: the first vertex of a face passes straight to the output;
// any later vertex runs two three-term dot products on the shared multiplier
// (none on a degenerate face); the second vertex of a face first builds the
// axes by scaling shifts, two 32-step square roots and six 62-step divides on
// the shared sqrt/divide unit.
// A finished word sits in the output register; while out_stall is high it
// holds, and the next vertex is taken once the register is free.
// Reset clears the face state, axes and origin; the first vertex after
// reset always opens a face.
`default_nettype none
module planar_texcoord_generator #(
    parameter int UV_SCALE_SHIFT = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ptg_pkg::in_word_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ptg_pkg::out_word_t       out_data
);

    logic               busy_reg;
    ptg_pkg::in_word_t  hold_reg;
    logic               core_done;
    ptg_pkg::out_word_t core_word;
    logic               start;

    assign in_stall = busy_reg || out_valid;
    assign start    = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (start)
            hold_reg <= in_data;
    end

    ptg_core #(.UV_SCALE_SHIFT(UV_SCALE_SHIFT)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_word  (start ? in_data : hold_reg),
        .done     (core_done),
        .out_word (core_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            else if (core_done)
                busy_reg <= 1'b0;
            if (core_done)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
            out_data <= core_word;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> !out_valid)
        else $error("result overwrote a pending word");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("accepted vertex not in work");
    assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> busy_reg)
        else $error("result without a vertex");

endmodule
`default_nettype wire
